// File: sv/lpcd_pkg.sv
// shared types and constants of the length-prefixed command deframer
// no dependencies; used by every module of the block

package lpcd_pkg;

   // length fields are four little-endian bytes
   localparam int FIELD_BYTES = 4;
   localparam logic [1:0] FIELD_LAST = 2'(FIELD_BYTES - 1);

   // configuration register indexes
   localparam logic CSR_MAX_MESSAGE = 1'b0;
   localparam logic CSR_MAX_ARGUMENTS = 1'b1;

   localparam logic [31:0] MAX_MESSAGE_RESET = 32'd4096;
   localparam logic [31:0] MAX_ARGUMENTS_RESET = 32'(200 * 1000);

   // error codes
   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_TOO_LONG = 3'd1;
   localparam logic [2:0] ERR_TOO_MANY_ARGS = 3'd2;
   localparam logic [2:0] ERR_OVERRUN = 3'd3;
   localparam logic [2:0] ERR_LEFTOVER = 3'd4;
   localparam logic [2:0] ERR_CLOSED = 3'd5;

   // command kinds
   localparam logic [1:0] KIND_GET = 2'd0;
   localparam logic [1:0] KIND_SET = 2'd1;
   localparam logic [1:0] KIND_DEL = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // command words, character by character
   localparam logic [7:0] CMD_WORDS [0:2][0:2] = '{
      '{8'h67, 8'h65, 8'h74},   // get
      '{8'h73, 8'h65, 8'h74},   // set
      '{8'h64, 8'h65, 8'h6c}    // del
   };

   // queue between parser and output stage
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   localparam int TDATA_W = 48;

   // one parsed result on its way to the output stage
   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  data_out;
      logic [31:0] arg_index;
      logic        string_end;
      logic        frame_done;
      logic        seen_two;
      logic        seen_three;
      logic [2:0]  word_match;
      logic [2:0]  error_code;
   } rec_type;

endpackage

// File: sv/lpcd_front.sv
// parser front end: accepts stream bytes, tracks framing state, builds result records
// depends on lpcd_pkg

module lpcd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata,
   input  logic              take,
   input  logic [7:0]        byte_in,
   output lpcd_pkg::rec_type rec
);

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_COUNT   = 4'b0010,
      PH_STRLEN  = 4'b0100,
      PH_STRDATA = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        halted_ff, halted_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] payload_ff, payload_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] seen_ff, seen_in;
   logic [31:0] sbl_ff, sbl_in;
   logic [2:0]  fwm_ff, fwm_in;
   logic [31:0] max_msg_ff, max_args_ff;

   logic [31:0] field_val;
   logic        field_last;
   logic [31:0] pl_dec;
   logic [31:0] sbl_dec;
   logic [31:0] seen_inc;
   logic        ap_en;
   logic [31:0] ap_seen;
   logic [31:0] ap_exp;
   logic [31:0] ap_pl;
   logic [1:0]  char_pos;

   assign field_val  = shift_ff | ({24'd0, byte_in} << {pos_ff, 3'b000});
   assign field_last = (pos_ff == lpcd_pkg::FIELD_LAST);
   assign pl_dec     = payload_ff - 32'd1;
   assign sbl_dec    = sbl_ff - 32'd1;
   assign seen_inc   = seen_ff + 32'd1;
   assign char_pos   = 2'd3 - sbl_ff[1:0];

   always_comb begin
      phase_in    = phase_ff;
      halted_in   = halted_ff;
      pos_in      = pos_ff;
      shift_in    = shift_ff;
      payload_in  = payload_ff;
      expected_in = expected_ff;
      seen_in     = seen_ff;
      sbl_in      = sbl_ff;
      fwm_in      = fwm_ff;
      rec         = '0;
      ap_en       = 1'b0;
      ap_seen     = seen_ff;
      ap_exp      = expected_ff;
      ap_pl       = pl_dec;

      if (take) begin
         if (halted_ff) begin
            rec.error_code = lpcd_pkg::ERR_CLOSED;
         end else begin
            // length fields share one assembler
            if (phase_ff != PH_STRDATA) begin
               if (field_last) begin
                  pos_in   = 2'd0;
                  shift_in = 32'd0;
               end else begin
                  pos_in   = pos_ff + 2'd1;
                  shift_in = field_val;
               end
            end
            unique case (phase_ff)
               PH_HEADER: begin
                  if (field_last) begin
                     if (field_val > max_msg_ff) begin
                        rec.error_code = lpcd_pkg::ERR_TOO_LONG;
                        halted_in      = 1'b1;
                     end else if (field_val < 32'(lpcd_pkg::FIELD_BYTES)) begin
                        rec.error_code = lpcd_pkg::ERR_OVERRUN;
                        halted_in      = 1'b1;
                     end else begin
                        payload_in = field_val;
                        phase_in   = PH_COUNT;
                     end
                  end
               end
               PH_COUNT: begin
                  payload_in = pl_dec;
                  if (field_last) begin
                     if (field_val > max_args_ff) begin
                        rec.error_code = lpcd_pkg::ERR_TOO_MANY_ARGS;
                        halted_in      = 1'b1;
                     end else begin
                        expected_in = field_val;
                        seen_in     = 32'd0;
                        fwm_in      = 3'd0;
                        ap_en       = 1'b1;
                        ap_seen     = 32'd0;
                        ap_exp      = field_val;
                     end
                  end
               end
               PH_STRLEN: begin
                  payload_in = pl_dec;
                  if (field_last) begin
                     if (field_val > pl_dec) begin
                        rec.error_code = lpcd_pkg::ERR_OVERRUN;
                        halted_in      = 1'b1;
                     end else begin
                        if (seen_ff == 32'd0) begin
                           fwm_in = (field_val == 32'd3) ? 3'b111 : 3'b000;
                        end
                        if (field_val == 32'd0) begin
                           // empty argument ends on its length field
                           rec.string_end = 1'b1;
                           rec.arg_index  = seen_ff;
                           seen_in        = seen_inc;
                           ap_en          = 1'b1;
                           ap_seen        = seen_inc;
                        end else begin
                           sbl_in   = field_val;
                           phase_in = PH_STRDATA;
                        end
                     end
                  end
               end
               PH_STRDATA: begin
                  rec.byte_valid = 1'b1;
                  rec.data_out   = byte_in;
                  rec.arg_index  = seen_ff;
                  // narrow the command word candidates on the first argument
                  if (seen_ff == 32'd0 && sbl_ff != 32'd0 && sbl_ff <= 32'd3) begin
                     for (int k = 0; k < 3; k++) begin
                        if (lpcd_pkg::CMD_WORDS[k][char_pos] != byte_in) begin
                           fwm_in[k] = 1'b0;
                        end
                     end
                  end
                  payload_in = pl_dec;
                  sbl_in     = sbl_dec;
                  if (sbl_dec == 32'd0) begin
                     rec.string_end = 1'b1;
                     seen_in        = seen_inc;
                     ap_en          = 1'b1;
                     ap_seen        = seen_inc;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase

            // what follows a finished count or argument
            if (ap_en) begin
               if (ap_seen == ap_exp) begin
                  if (ap_pl == 32'd0) begin
                     rec.frame_done = 1'b1;
                     rec.seen_two   = (ap_seen == 32'd2);
                     rec.seen_three = (ap_seen == 32'd3);
                     rec.word_match = fwm_in;
                     phase_in       = PH_HEADER;
                  end else begin
                     rec.error_code = lpcd_pkg::ERR_LEFTOVER;
                     halted_in      = 1'b1;
                  end
               end else if (ap_pl < 32'(lpcd_pkg::FIELD_BYTES)) begin
                  rec.error_code = lpcd_pkg::ERR_OVERRUN;
                  halted_in      = 1'b1;
               end else begin
                  phase_in = PH_STRLEN;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         halted_ff   <= 1'b0;
         pos_ff      <= 2'd0;
         shift_ff    <= 32'd0;
         payload_ff  <= 32'd0;
         expected_ff <= 32'd0;
         seen_ff     <= 32'd0;
         sbl_ff      <= 32'd0;
         fwm_ff      <= 3'd0;
         max_msg_ff  <= lpcd_pkg::MAX_MESSAGE_RESET;
         max_args_ff <= lpcd_pkg::MAX_ARGUMENTS_RESET;
      end else begin
         phase_ff    <= phase_in;
         halted_ff   <= halted_in;
         pos_ff      <= pos_in;
         shift_ff    <= shift_in;
         payload_ff  <= payload_in;
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         sbl_ff      <= sbl_in;
         fwm_ff      <= fwm_in;
         if (csr_we) begin
            unique case (csr_index)
               lpcd_pkg::CSR_MAX_MESSAGE:   max_msg_ff  <= csr_wdata;
               lpcd_pkg::CSR_MAX_ARGUMENTS: max_args_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// File: sv/lpcd_fifo.sv
// short record queue between parser front end and output stage
// depends on lpcd_pkg

module lpcd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpcd_pkg::rec_type push_rec,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lpcd_pkg::rec_type head_rec
);

   localparam int AW = lpcd_pkg::FIFO_AW;

   lpcd_pkg::rec_type mem_ff [lpcd_pkg::FIFO_DEPTH];
   lpcd_pkg::rec_type head_ff;
   logic          head_valid_ff, head_valid_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          load_head;
   logic          from_mem;
   logic          bypass;
   logic          mem_push;

   // records behind the head register wait in the array
   assign full       = (count_ff == (AW+1)'(lpcd_pkg::FIFO_DEPTH));
   assign head_valid = head_valid_ff;
   assign head_rec   = head_ff;

   assign load_head = !head_valid_ff || pop;
   assign from_mem  = load_head && (count_ff != '0);
   // nothing queued and the head register free or being popped: a new record goes straight to the head register
   assign bypass    = load_head && (count_ff == '0) && push;
   assign mem_push  = push && !bypass;

   always_comb begin
      wr_ptr_in     = mem_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in     = from_mem ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in      = count_ff + (AW+1)'(mem_push) - (AW+1)'(from_mem);
      head_valid_in = load_head ? (from_mem || bypass) : head_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
      if (from_mem) begin
         head_ff <= mem_ff[rd_ptr_ff];
      end else if (bypass) begin
         head_ff <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (mem_push && !from_mem) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
   a_head_before_queue: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> head_valid_ff)
      else $error("queued records behind an empty head");
`endif

endmodule

// File: sv/lpcd_back.sv
// output stage: classifies finished frames and holds the result transaction
// depends on lpcd_pkg

module lpcd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  lpcd_pkg::rec_type            head_rec,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [lpcd_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);

   logic                         valid_ff, valid_in;
   logic [lpcd_pkg::TDATA_W-1:0] data_ff, data_in;
   logic                         user_ff, user_in;
   logic                         last_ff, last_in;
   logic [1:0]                   kind;

   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      kind = 2'd0;
      if (head_rec.frame_done) begin
         if (head_rec.seen_two && head_rec.word_match[0]) begin
            kind = lpcd_pkg::KIND_GET;
         end else if (head_rec.seen_three && head_rec.word_match[1]) begin
            kind = lpcd_pkg::KIND_SET;
         end else if (head_rec.seen_two && head_rec.word_match[2]) begin
            kind = lpcd_pkg::KIND_DEL;
         end else begin
            kind = lpcd_pkg::KIND_UNKNOWN;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = {2'b00, head_rec.error_code, kind, head_rec.string_end,
                     head_rec.arg_index, head_rec.data_out};
         user_in  = head_rec.byte_valid;
         last_in  = head_rec.frame_done;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: sv/length_prefixed_command_deframer.sv
// length-prefixed command deframer; results pass the queue head and output registers
// one byte accepted and one result delivered per cycle when both sides flow
// each byte leaves one result; 4 queued records plus a head register decouple the sides
// parser state advances one byte per cycle while the queue has room
// synchronous active-high reset: parser to frame header, limits to defaults, queue empty
// after any framing error the block answers every byte with error closed until reset

module length_prefixed_command_deframer (
   input  logic                         clock,
   input  logic                         reset,
   // configuration write port
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [31:0]                  csr_wdata,
   // request byte stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] byte_in
   // result stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [7:0] data_out, [39:8] arg_index, [40] string_end,
   // [42:41] command_kind, [45:43] error_code, [47:46] zero
   output logic [lpcd_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                         rsp_tuser,   // byte_valid
   output logic                         rsp_tlast    // frame_done
);

   lpcd_pkg::rec_type front_rec;
   lpcd_pkg::rec_type head_rec;
   logic              take;
   logic              fifo_full;
   logic              head_valid;
   logic              pop;

   // a byte enters whenever the queue has room
   assign req_tready = !fifo_full;
   assign take       = req_tvalid && req_tready;

   // parser: framing state, limit checks, command word tracking
   lpcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .byte_in   (req_tdata),
      .rec       (front_rec)
   );

   // records wait here while the result side is stalled
   lpcd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_rec   (front_rec),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   // classification and output register
   lpcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[45:43] == lpcd_pkg::ERR_NONE))
      else $error("finished frame carries an error");
   a_kind_only_at_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[42:41] == 2'd0))
      else $error("command kind outside a finished frame");
   a_closed_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[45:43] != lpcd_pkg::ERR_CLOSED))
      else $error("string byte passed after close");
`endif

endmodule
